[rtl/sha1_pkg.sv]
// Shared types and constants of the SHA-1 hash engine.
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] digest_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP_ROUND,
    ST_COMP_UPDATE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    BSEL_INPUT,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic       push;        // absorb one byte into the word assembler
    byte_sel_t  byte_sel;
    logic       word_done;   // pushed byte completes a word
    logic       count_byte;  // message byte, bump the length counter
    logic       latch_len;
    logic       shift_len;
    logic       load_vars;
    logic       round;
    logic [1:0] phase;       // round group of twenty
    logic       early;       // rounds 0..15 read the schedule directly
    logic       update;
    logic       finish;
  } dp_cmd_t;

  localparam int ROUNDS = 80;
  localparam logic [5:0] PAD_POS   = 6'd56;
  localparam logic [5:0] BLOCK_END = 6'd63;
  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

  localparam digest_t INIT_VALUE = '{
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam word_t ROUND_CONST [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

endpackage

[rtl/sha1_ctrl.sv]
// Sequencer: byte intake, padding, round counting and digest hand-off.
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    byte_present,
  input  logic    end_of_message,
  input  logic    out_busy,
  output logic    item_stall,
  output dp_cmd_t cmd
);

  state_t     state, state_next;
  state_t     ret, ret_next;
  logic [6:0] rnd, rnd_next;
  logic [5:0] pos, pos_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      rnd   <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      rnd   <= rnd_next;
      pos   <= pos_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    rnd_next   = rnd;
    pos_next   = pos;
    cmd        = '0;
    item_stall = 1'b1;
    cmd.word_done = (pos[1:0] == 2'd3);
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (byte_present) begin
            cmd.push       = 1'b1;
            cmd.byte_sel   = BSEL_INPUT;
            cmd.count_byte = 1'b1;
            pos_next       = pos + 6'd1;
            if (pos == BLOCK_END) begin
              cmd.load_vars = 1'b1;
              rnd_next      = '0;
              ret_next      = end_of_message ? ST_PAD_MARK : ST_IDLE;
              state_next    = ST_COMP_ROUND;
            end else if (end_of_message) begin
              state_next = ST_PAD_MARK;
            end
          end else if (end_of_message) begin
            state_next = ST_PAD_MARK;
          end
        end
      end
      ST_COMP_ROUND: begin
        cmd.round = 1'b1;
        cmd.early = (rnd < 7'd16);
        if (rnd < 7'd20)      cmd.phase = 2'd0;
        else if (rnd < 7'd40) cmd.phase = 2'd1;
        else if (rnd < 7'd60) cmd.phase = 2'd2;
        else                  cmd.phase = 2'd3;
        if (rnd == 7'(ROUNDS - 1)) begin
          state_next = ST_COMP_UPDATE;
        end else begin
          rnd_next = rnd + 7'd1;
        end
      end
      ST_COMP_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ret;
      end
      ST_PAD_MARK: begin
        cmd.push      = 1'b1;
        cmd.byte_sel  = BSEL_MARK;
        cmd.latch_len = 1'b1;
        pos_next      = pos + 6'd1;
        state_next    = ST_PAD_ZERO;
        if (pos == BLOCK_END) begin
          cmd.load_vars = 1'b1;
          rnd_next      = '0;
          ret_next      = ST_PAD_ZERO;
          state_next    = ST_COMP_ROUND;
        end
      end
      ST_PAD_ZERO: begin
        if (pos == PAD_POS) begin
          state_next = ST_PAD_LEN;
        end else begin
          cmd.push     = 1'b1;
          cmd.byte_sel = BSEL_ZERO;
          pos_next     = pos + 6'd1;
          if (pos == BLOCK_END) begin
            cmd.load_vars = 1'b1;
            rnd_next      = '0;
            ret_next      = ST_PAD_ZERO;
            state_next    = ST_COMP_ROUND;
          end
        end
      end
      ST_PAD_LEN: begin
        cmd.push      = 1'b1;
        cmd.byte_sel  = BSEL_LEN;
        cmd.shift_len = 1'b1;
        pos_next      = pos + 6'd1;
        if (pos == BLOCK_END) begin
          cmd.load_vars = 1'b1;
          rnd_next      = '0;
          ret_next      = ST_FINISH;
          state_next    = ST_COMP_ROUND;
        end
      end
      ST_FINISH: begin
        // wait until the previous digest has drained
        if (!out_busy) begin
          cmd.finish = 1'b1;
          pos_next   = '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/sha1_datapath.sv]
// Word assembly, rolling message schedule, round logic and chaining value.
module sha1_datapath
  import sha1_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  dp_cmd_t cmd,
  input  logic [7:0] data_byte,
  output digest_t digest
);

  word_t        asm_word;
  word_t        sched [16];
  word_t        v [5];
  digest_t      cv;
  logic [60:0]  count;
  logic [63:0]  len;

  logic [7:0]   byte_val;
  word_t        asm_next;
  word_t        w;
  word_t        w_mix;
  word_t        f;
  word_t        tmp;
  logic         sched_shift;
  word_t        sched_in;

  always_comb begin
    unique case (cmd.byte_sel)
      BSEL_INPUT: byte_val = data_byte;
      BSEL_MARK:  byte_val = PAD_MARK_BYTE;
      BSEL_ZERO:  byte_val = 8'h00;
      BSEL_LEN:   byte_val = len[63:56];
      default:    byte_val = 8'h00;
    endcase
  end

  assign asm_next = {asm_word[23:0], byte_val};

  assign w_mix = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign w     = cmd.early ? sched[0] : {w_mix[30:0], w_mix[31]};

  always_comb begin
    unique case (cmd.phase)
      2'd0:    f = (v[1] & v[2]) | (~v[1] & v[3]);
      2'd2:    f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
      default: f = v[1] ^ v[2] ^ v[3];
    endcase
  end

  assign tmp = {v[0][26:0], v[0][31:27]} + f + v[4] + ROUND_CONST[cmd.phase] + w;

  // schedule shifts on a completed word and on every round
  assign sched_shift = (cmd.push && cmd.word_done) || cmd.round;
  assign sched_in    = cmd.round ? w : asm_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      asm_word <= '0;
      cv       <= INIT_VALUE;
      count    <= '0;
    end else begin
      if (cmd.finish) begin
        asm_word <= '0;
        cv       <= INIT_VALUE;
        count    <= '0;
      end else begin
        if (cmd.push) asm_word <= asm_next;
        if (cmd.count_byte) count <= count + 61'd1;
        if (cmd.update) begin
          for (int i = 0; i < 5; i++) cv[i] <= cv[i] + v[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sched_shift) begin
      for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
      sched[15] <= sched_in;
    end
    if (cmd.load_vars) begin
      for (int i = 0; i < 5; i++) v[i] <= cv[i];
    end else if (cmd.round) begin
      v[4] <= v[3];
      v[3] <= v[2];
      v[2] <= {v[1][1:0], v[1][31:2]};
      v[1] <= v[0];
      v[0] <= tmp;
    end
    if (cmd.latch_len) begin
      len <= {count, 3'b000};
    end else if (cmd.shift_len) begin
      len <= {len[55:0], 8'h00};
    end
  end

  assign digest = cv;

endmodule

[rtl/sha1_outbuf.sv]
// Digest output buffer: holds one digest and hands it out a word at a time.
module sha1_outbuf
  import sha1_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  digest_t    digest,
  input  logic       digest_stall,
  output logic       digest_valid,
  output word_t      digest_word,
  output logic [2:0] word_index,
  output logic       last_word,
  output logic       busy
);

  word_t      words [5];
  logic       valid;
  logic [2:0] idx;
  logic       take;

  assign take = valid && !digest_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (take) begin
      if (idx == 3'd4) begin
        valid <= 1'b0;
        idx   <= '0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 5; i++) words[i] <= digest[i];
    end else if (take) begin
      for (int i = 0; i < 4; i++) words[i] <= words[i + 1];
    end
  end

  assign digest_valid = valid;
  assign digest_word  = words[0];
  assign word_index   = idx;
  assign last_word    = (idx == 3'd4);
  assign busy         = valid;

endmodule

[rtl/sha1_hash_engine.sv]
// SHA-1 engine top: one byte per item in, five digest words out per message.
// Each byte is taken in the idle state; the byte closing a 64-byte block starts a compression
// (80 rounds of the single round unit, then the chaining update), during which input stalls.
// End of message: the padding bytes are pushed one at a time, then 1 or 2 compressions, then a finish
// step, held off until the previous digest has left the buffer.
// Digest words leave one per cycle while digest_stall is low, from a buffer while the next message streams in.
// Synchronous reset loads the initial chaining value and clears counters.
module sha1_hash_engine
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  dp_cmd_t cmd;
  digest_t digest;
  logic    out_busy;

  sha1_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_busy       (out_busy),
    .item_stall     (item_stall),
    .cmd            (cmd)
  );

  sha1_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (data_byte),
    .digest    (digest)
  );

  sha1_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .load         (cmd.finish),
    .digest       (digest),
    .digest_stall (digest_stall),
    .digest_valid (digest_valid),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word),
    .busy         (out_busy)
  );

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> word_index <= 3'd4)
    else $error("digest word index out of range");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_stall && !last_word |=> digest_valid)
    else $error("digest stopped before its last word");

  a_restart_index: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_stall && last_word |=> word_index == 3'd0)
    else $error("next digest does not start at word zero");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (cmd.round || cmd.update) |-> item_stall)
    else $error("input taken during compression");

endmodule
